FILE: src/qdpt_pkg.sv
// qdpt_pkg: shared types and constants for the quadrature decoder / period timer.
// No dependencies.
package qdpt_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_PINS  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef logic signed [1:0] dir_t;

    localparam dir_t DIR_ZERO = 2'sb00;
    localparam dir_t DIR_FWD  = 2'sb01;
    localparam dir_t DIR_REV  = 2'sb11;

    localparam logic [15:0] MARKER_RESET = 16'd60000;

    // step for index {B_new, A_new, B_old, A_old}; double changes step 0
    localparam dir_t STEP_TABLE [16] = '{
        DIR_ZERO, DIR_FWD,  DIR_REV,  DIR_ZERO,
        DIR_REV,  DIR_ZERO, DIR_ZERO, DIR_FWD,
        DIR_FWD,  DIR_ZERO, DIR_ZERO, DIR_REV,
        DIR_ZERO, DIR_REV,  DIR_FWD,  DIR_ZERO
    };

endpackage

FILE: src/qdpt_in_if.sv
// qdpt_in_if: input channel, valid/ready with op and encoder levels.
// Depends on qdpt_pkg.
interface qdpt_in_if;
    logic            valid;
    logic            ready;
    qdpt_pkg::op_t   op;
    logic            chan_a;
    logic            chan_b;

    modport source (output valid, output op, output chan_a, output chan_b, input ready);
    modport sink   (input valid, input op, input chan_a, input chan_b, output ready);
endinterface

FILE: src/qdpt_out_if.sv
// qdpt_out_if: result channel, valid/ready with position, direction, period, count.
// Depends on qdpt_pkg.
interface qdpt_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        position;
    qdpt_pkg::dir_t     direction;
    logic [15:0]        period;
    logic [7:0]         event_count;

    modport source (output valid, output position, output direction, output period,
                    output event_count, input ready);
    modport sink   (input valid, input position, input direction, input period,
                    input event_count, output ready);
endinterface

FILE: src/quadrature_decoder_period_timer.sv
// Quadrature decoder with edge-to-edge period measurement.
// Latency: a result beat is valid the cycle after its input beat is accepted.
// Throughput: one input beat per cycle; the state registers double as the
//   result register, so a new beat is taken whenever the result slot is empty
//   or being drained in the same cycle.
// Reset (rst_n low, async): all state zero, marker 60000, no result pending.
module quadrature_decoder_period_timer #(
    parameter int TIMER_BITS    = 16,
    parameter int POSITION_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    qdpt_in_if.sink             item,
    qdpt_out_if.source          result
);

    localparam int TIMER_EXT = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int POS_EXT   = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    // state; these registers are also what the result beat shows
    logic [15:0]                marker_reg;
    logic [1:0]                 prev_pins_reg, prev_pins_next;
    logic [POSITION_BITS-1:0]   pos_reg, pos_next;
    qdpt_pkg::dir_t             dir_reg, dir_next;
    logic [15:0]                period_reg, period_next;
    logic [TIMER_BITS-1:0]      timer_reg, timer_next;
    logic [7:0]                 events_reg, events_next;
    logic                       out_valid_reg;

    logic                       accept;
    logic [3:0]                 step_idx;
    qdpt_pkg::dir_t             step;
    logic [TIMER_BITS-1:0]      timer_inc;
    logic [TIMER_EXT-1:0]       timer_wide;
    logic [POS_EXT-1:0]         pos_wide;

    // result slot frees up when empty or drained this cycle
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    assign step_idx  = {item.chan_b, item.chan_a, prev_pins_reg};
    assign step      = qdpt_pkg::STEP_TABLE[step_idx];
    assign timer_inc = timer_reg + TIMER_BITS'(1);
    assign timer_wide = TIMER_EXT'(timer_reg);

    always_comb
    begin
        prev_pins_next = prev_pins_reg;
        pos_next       = pos_reg;
        dir_next       = dir_reg;
        period_next    = period_reg;
        timer_next     = timer_reg;
        events_next    = events_reg;
        case (item.op)
            qdpt_pkg::OP_TICK:
            begin
                timer_next = timer_inc;
                // timer wrap: no reading
                if (timer_inc == '0)
                begin
                    period_next = marker_reg;
                    dir_next    = qdpt_pkg::DIR_ZERO;
                end
            end
            qdpt_pkg::OP_PINS:
            begin
                prev_pins_next = {item.chan_b, item.chan_a};
                pos_next       = pos_reg + {{(POSITION_BITS-2){step[1]}}, step};
                // same direction (or fresh start) gives a valid interval;
                // reversal or a stationary step after motion gives the marker
                if ((step == dir_reg) || (dir_reg == qdpt_pkg::DIR_ZERO))
                begin
                    period_next = timer_wide[15:0];
                    dir_next    = step;
                end
                else
                begin
                    period_next = marker_reg;
                    dir_next    = qdpt_pkg::DIR_ZERO;
                end
                timer_next  = '0;
                events_next = events_reg + 8'd1;
            end
            qdpt_pkg::OP_CLEAR:
            begin
                pos_next = '0;
            end
            default:
            begin
                // unused code: state holds
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= qdpt_pkg::MARKER_RESET;
        end
        else if (cfg_we)
        begin
            marker_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= '0;
            pos_reg       <= '0;
            dir_reg       <= qdpt_pkg::DIR_ZERO;
            period_reg    <= '0;
            timer_reg     <= '0;
            events_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_pins_reg <= prev_pins_next;
                pos_reg       <= pos_next;
                dir_reg       <= dir_next;
                period_reg    <= period_next;
                timer_reg     <= timer_next;
                events_reg    <= events_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign pos_wide           = POS_EXT'(pos_reg);
    assign result.valid       = out_valid_reg;
    assign result.position    = pos_wide[15:0];
    assign result.direction   = dir_reg;
    assign result.period      = period_reg;
    assign result.event_count = events_reg;

endmodule

FILE: src/qdpt_checker.sv
// qdpt_checker: port-level assertions for quadrature_decoder_period_timer.
// Depends on qdpt_pkg; bound to the top level below.
module qdpt_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input qdpt_pkg::op_t        in_op,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [15:0]          out_position,
    input qdpt_pkg::dir_t       out_direction,
    input logic [15:0]          out_period,
    input logic [7:0]           out_event_count
);

    // stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_position)
            && $stable(out_direction) && $stable(out_period) && $stable(out_event_count))
        else $error("result beat changed while stalled");

    // every accepted beat yields a result the next cycle
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // a clear beat zeroes the reported position
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_op == qdpt_pkg::OP_CLEAR) |=> out_position == 16'd0)
        else $error("position not zero after clear");

    // direction is only ever -1, 0 or +1
    a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_direction != 2'sb10)
        else $error("illegal direction code");

endmodule

bind quadrature_decoder_period_timer qdpt_checker u_qdpt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (item.valid),
    .in_ready        (item.ready),
    .in_op           (item.op),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_position    (result.position),
    .out_direction   (result.direction),
    .out_period      (result.period),
    .out_event_count (result.event_count)
);
